/* rtl/clp_pkg.sv */
// Shared types, constants and name tables for the color list parser.
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

  // Token buffer capacity; length saturates one below it.
  localparam int TOKEN_CAPACITY = 32;
  localparam int TOK_LEN_W      = $clog2(TOKEN_CAPACITY);
  localparam logic [TOK_LEN_W-1:0] TOK_LEN_MAX = TOK_LEN_W'(TOKEN_CAPACITY - 1);

  localparam int NAME_COUNT = 8;
  localparam int NAME_SLOTS = 8;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] MAX_COLORS_RESET = 8'd16;

  // Separator characters and the hash that opens a hex token.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [7:0] DOUBLE_NIBBLE = 8'h11;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

  // Lower-case name letters, zero padded.
  localparam logic [7:0] NAME_TEXT [NAME_COUNT][NAME_SLOTS] = '{
    '{"v", "i", "o", "l", "e", "t", 8'h00, 8'h00},
    '{"b", "l", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "r", "e", "e", "n", 8'h00, 8'h00, 8'h00},
    '{"y", "e", "l", "l", "o", "w", 8'h00, 8'h00},
    '{"a", "m", "b", "e", "r", 8'h00, 8'h00, 8'h00},
    '{"o", "r", "a", "n", "g", "e", 8'h00, 8'h00},
    '{"r", "e", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "t", "e", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
    3'd6, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd3, 3'd5
  };

  localparam logic [31:0] NAME_RGBA [NAME_COUNT] = '{
    32'h8B00FFFF, 32'h1A66FFFF, 32'h22DD22FF, 32'hFFD400FF,
    32'hFFB000FF, 32'hFF7A00FF, 32'hFF1E10FF, 32'hFFFFFFFF
  };

  // Finished token handed from front to back.
  typedef struct packed {
    logic        nul;       // token ended by NUL: end of list
    logic        color_ok;  // token parsed to a color
    logic [31:0] rgba;
  } tok_rec_t;

endpackage

`default_nettype wire

/* rtl/clp_front.sv */
// Front end: takes text bytes, tracks token state, emits one request per separator.
`timescale 1ns / 1ps
`default_nettype none

module clp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        char_in,
  input  wire logic              accept,
  output      logic              push,
  output      clp_pkg::tok_rec_t rec
);
  import clp_pkg::*;

  logic [TOK_LEN_W-1:0]  token_length;
  logic                  starts_with_hash;
  logic [31:0]           hex_digits;
  logic                  all_hex_so_far;
  logic [NAME_COUNT-1:0] name_candidates;

  logic                  sep;
  logic [7:0]            lc;
  logic                  is_hex;
  logic [3:0]            nib;
  logic [NAME_COUNT-1:0] cand_next;
  logic                  hex_ok;
  logic                  name_ok;
  logic [31:0]           name_color;
  logic [31:0]           hex_color;

  assign sep = (char_in == CH_NUL) || (char_in == CH_SPACE) || (char_in == CH_COMMA) ||
               (char_in == CH_TAB) || (char_in == CH_LF);

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (char_in >= "0" && char_in <= "9") begin
      nib = 4'(char_in - "0");
    end else if (char_in >= "a" && char_in <= "f") begin
      nib = 4'(char_in - "a" + 8'd10);
    end else if (char_in >= "A" && char_in <= "F") begin
      nib = 4'(char_in - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign lc = (char_in >= "A" && char_in <= "Z") ? char_in + 8'd32 : char_in;

  // Drop a name once the position runs past it or the letter differs.
  always_comb begin
    cand_next = name_candidates;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (token_length >= TOK_LEN_W'(NAME_LEN[i])) begin
        cand_next[i] = 1'b0;
      end else if (NAME_TEXT[i][token_length[2:0]] != lc) begin
        cand_next[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_length     <= '0;
      starts_with_hash <= 1'b0;
      hex_digits       <= '0;
      all_hex_so_far   <= 1'b1;
      name_candidates  <= '1;
    end else if (accept) begin
      if (sep) begin
        token_length     <= '0;
        starts_with_hash <= 1'b0;
        hex_digits       <= '0;
        all_hex_so_far   <= 1'b1;
        name_candidates  <= '1;
      end else if (token_length != TOK_LEN_MAX) begin
        if (token_length == '0 && char_in == CH_HASH) begin
          starts_with_hash <= 1'b1;
        end
        if (token_length != '0) begin
          if (is_hex) begin
            hex_digits <= {hex_digits[27:0], nib};
          end else begin
            all_hex_so_far <= 1'b0;
          end
        end
        name_candidates <= cand_next;
        token_length    <= token_length + 1'b1;
      end
    end
  end

  // Decide the finished token from the stored state.
  always_comb begin
    hex_color = hex_digits;
    hex_ok    = 1'b0;
    if (starts_with_hash && all_hex_so_far) begin
      if (token_length == TOK_LEN_W'(4)) begin
        hex_ok    = 1'b1;
        hex_color = {hex_digits[11:8], hex_digits[11:8], hex_digits[7:4], hex_digits[7:4],
                     hex_digits[3:0], hex_digits[3:0], ALPHA_OPAQUE};
      end else if (token_length == TOK_LEN_W'(7)) begin
        hex_ok    = 1'b1;
        hex_color = {hex_digits[23:0], ALPHA_OPAQUE};
      end else if (token_length == TOK_LEN_W'(9)) begin
        hex_ok    = 1'b1;
        hex_color = hex_digits;
      end
    end
  end

  always_comb begin
    name_ok    = 1'b0;
    name_color = '0;
    for (int i = NAME_COUNT - 1; i >= 0; i--) begin
      if (name_candidates[i] && token_length == TOK_LEN_W'(NAME_LEN[i])) begin
        name_ok    = 1'b1;
        name_color = NAME_RGBA[i];
      end
    end
  end

  assign push         = accept && sep;
  assign rec.nul      = (char_in == CH_NUL);
  assign rec.color_ok = (token_length != '0) && (starts_with_hash ? hex_ok : name_ok);
  assign rec.rgba     = starts_with_hash ? hex_color : name_color;

endmodule

`default_nettype wire

/* rtl/clp_queue.sv */
// Short request queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module clp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire clp_pkg::tok_rec_t din,
  input  wire logic              pop,
  output      clp_pkg::tok_rec_t dout,
  output      logic              full,
  output      logic              empty
);
  import clp_pkg::*;

  tok_rec_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/clp_back.sv */
// Back end: applies the color limit, counts colors, holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module clp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_data,
  input  wire clp_pkg::tok_rec_t rec,
  input  wire logic              rec_avail,
  output      logic              pop,
  output      logic [31:0]       rgba,
  output      logic              color_valid,
  output      logic [7:0]        colors_so_far,
  output      logic              end_of_list,
  output      logic              out_valid,
  input  wire logic              out_stall
);
  import clp_pkg::*;

  logic [7:0] max_colors;
  logic [7:0] colors_found;
  logic [7:0] found_inc;
  logic       take;
  logic       emit;

  assign pop       = rec_avail && (!out_valid || !out_stall);
  assign take      = rec.color_ok && (colors_found < max_colors);
  assign emit      = rec.nul || take;
  assign found_inc = colors_found + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_colors <= MAX_COLORS_RESET;
    end else if (cfg_we) begin
      max_colors <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colors_found <= '0;
      out_valid    <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
      if (rec.nul) begin
        colors_found <= '0;
      end else if (take) begin
        colors_found <= found_inc;
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk) begin
    if (pop) begin
      rgba          <= take ? rec.rgba : '0;
      color_valid   <= take;
      colors_so_far <= take ? found_inc : colors_found;
      end_of_list   <= rec.nul;
    end
  end

endmodule

`default_nettype wire

/* rtl/color_list_parser_core.sv */
// Top level of the color list parser: front end, request queue, back end.
//
// Usage:
//   Input channel (in_valid / in_stall / char_in) carries one text byte per
//   request. Space, comma, tab, LF and NUL end a token; NUL also ends the list.
//   Output channel (out_valid / out_stall / rgba, color_valid, colors_so_far,
//   end_of_list) carries one result per color within max_colors, one per NUL.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes max_colors; it is
//   always ready and should only be written while the block is idle.
// Throughput: one byte per cycle while the queue is not full. Token state
//   updates in the front end; back end pops a request per cycle unless stalled.
// Path: a separator's request enters a queue slot when the byte is accepted;
//   the back end then pops it and registers the result in its output register.
// Stall: when out_stall holds, the output register keeps its result, the back
//   stops popping and the 4-entry queue fills; in_stall rises only when the
//   queue is full. Non-separator bytes still need a free slot to be taken.
// Reset (rst, synchronous): token state and color count clear, queue empties,
//   out_valid drops, max_colors returns to 16.
`timescale 1ns / 1ps
`default_nettype none

module color_list_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // text bytes
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  char_in,
  // results
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] rgba,
  output      logic        color_valid,
  output      logic [7:0]  colors_so_far,
  output      logic        end_of_list,
  // max_colors register
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [7:0]  cfg_data
);
  import clp_pkg::*;

  logic     accept;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  tok_rec_t front_rec;
  tok_rec_t back_rec;

  // Stall only on a full queue so bytes flow while results wait.
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  clp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .accept  (accept),
    .push    (push),
    .rec     (front_rec)
  );

  clp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_rec),
    .pop   (pop),
    .dout  (back_rec),
    .full  (q_full),
    .empty (q_empty)
  );

  clp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .rec           (back_rec),
    .rec_avail     (!q_empty),
    .pop           (pop),
    .rgba          (rgba),
    .color_valid   (color_valid),
    .colors_so_far (colors_so_far),
    .end_of_list   (end_of_list),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

endmodule

`default_nettype wire
